### rtl/core/hsv_rgb_pkg.sv
// Shared types, constants and helpers for the HSV to RGB565 converter.
// Depends on nothing; every other file in rtl/core but hsv_rgb_checker uses it by scoped name.
`default_nettype none

package hsv_rgb_pkg;

  // Full scale of an 8-bit level (255 stands for 1.0).
  localparam logic [7:0]  FullLevel = 8'd255;
  // Full scale of the q/t numerator: 255 * 65536.
  localparam logic [23:0] DenFull   = 24'd16711680;

  // Hue sector, one sixth of a turn each.
  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_t;

  // After stage 1: sector split off, p numerator formed.
  typedef struct packed {
    sector_t     sector;
    logic [15:0] frac;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] p_num;
  } s1_word_t;

  // After stage 2: p finished, q/t scale factors formed.
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [23:0] q_fac;
    logic [23:0] t_fac;
  } s2_word_t;

  // After stage 3: q/t products scaled down by 65536.
  typedef struct packed {
    sector_t     sector;
    logic [7:0]  val;
    logic [7:0]  p;
    logic [15:0] q_num;
    logic [15:0] t_num;
  } s3_word_t;

  // floor(x / 255), exact for x <= 255*255 + 254.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    sum = {1'b0, x} + 17'd1 + {9'd0, x[15:8]};
    return sum[15:8];
  endfunction

endpackage

`default_nettype wire

### rtl/core/hsv_to_rgb565.sv
// HSV to RGB565 pixel converter, top level.
// Depends on hsv_rgb_pkg, hsv_rgb_front, hsv_rgb_scale and hsv_rgb_pack.
//
// Usage:
//   Input channel: in_valid / in_stall carry one word of hue (16-bit fraction
//   of a turn), saturation and brightness (8-bit, 255 = full). A word is taken
//   on a rising edge with in_valid high and in_stall low.
//   Output channel: out_valid / out_stall carry one RGB565 color per input
//   word, in order (red 15..11, green 10..5, blue 4..0).
//   Throughput: one word per clock while the output is not stalled. Four
//   register stages (sector split, q/t factors, value multiply, channel select
//   and pack) each hold one word, with a valid bit traveling alongside.
//   Stall: each stage holds only while it is full and the stage after it
//   holds, so bubbles collapse and in_stall rises only once every stage is
//   full behind a stalled output. A held color does not change.
//   Reset: rst (synchronous, active high) drops all valid bits; words in
//   flight are lost and the block is ready in the next cycle.
`default_nettype none

module hsv_to_rgb565 (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [15:0] hue,
  input  wire logic [7:0]  saturation,
  input  wire logic [7:0]  brightness,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      color
);

  // Stage 2 -> stage 3 link
  logic                  s2_valid;
  logic                  s2_stall;
  hsv_rgb_pkg::s2_word_t s2_word;

  // Stage 3 -> stage 4 link
  logic                  s3_valid;
  logic                  s3_stall;
  hsv_rgb_pkg::s3_word_t s3_word;

  // Split the hue, form p and the q/t factors.
  hsv_rgb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (s2_valid),
    .out_stall  (s2_stall),
    .out_word   (s2_word)
  );

  // Multiply the factors by the value channel.
  hsv_rgb_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s2_valid),
    .in_stall  (s2_stall),
    .in_word   (s2_word),
    .out_valid (s3_valid),
    .out_stall (s3_stall),
    .out_word  (s3_word)
  );

  // Divide down, order the channels and pack into the output register.
  hsv_rgb_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s3_valid),
    .in_stall  (s3_stall),
    .in_word   (s3_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .color     (color)
  );

endmodule

`default_nettype wire

### rtl/core/hsv_rgb_front.sv
// Stages 1 and 2: hue sector split, p level, and q/t scale factors.
// Depends on hsv_rgb_pkg.
`default_nettype none

module hsv_rgb_front (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [15:0]           hue,
  input  wire logic [7:0]            saturation,
  input  wire logic [7:0]            brightness,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output hsv_rgb_pkg::s2_word_t      out_word
);

  logic                  s1_valid;
  hsv_rgb_pkg::s1_word_t s1_word;
  logic                  s1_stall;
  logic                  s2_stall;
  logic [18:0]           h6;
  logic [23:0]           frac_sat;

  assign s2_stall = out_valid && out_stall;
  assign s1_stall = s1_valid && s2_stall;
  assign in_stall = s1_stall;

  // hue * 6 as shift-and-add
  assign h6 = {1'b0, hue, 2'b00} + {2'b00, hue, 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!s1_stall) begin
      s1_valid <= in_valid;
    end
    if (!s1_stall && in_valid) begin
      s1_word.sector <= hsv_rgb_pkg::sector_t'(h6[18:16]);
      s1_word.frac   <= h6[15:0];
      s1_word.sat    <= saturation;
      s1_word.val    <= brightness;
      s1_word.p_num  <= 16'(brightness) * 16'(hsv_rgb_pkg::FullLevel - saturation);
    end
  end

  assign frac_sat = 24'(s1_word.frac) * 24'(s1_word.sat);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!s2_stall) begin
      out_valid <= s1_valid;
    end
    if (!s2_stall && s1_valid) begin
      out_word.sector <= s1_word.sector;
      out_word.val    <= s1_word.val;
      out_word.p      <= hsv_rgb_pkg::div255(s1_word.p_num);
      out_word.q_fac  <= hsv_rgb_pkg::DenFull - frac_sat;
      // (65536 - f) * S folded into S << 16 minus f * S
      out_word.t_fac  <= hsv_rgb_pkg::DenFull - {s1_word.sat, 16'd0} + frac_sat;
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsv_rgb_scale.sv
// Stage 3: scale the q/t factors by the value channel, drop the low 16 bits.
// Depends on hsv_rgb_pkg.
`default_nettype none

module hsv_rgb_scale (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire hsv_rgb_pkg::s2_word_t in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output hsv_rgb_pkg::s3_word_t      out_word
);

  logic        hold;
  logic [31:0] q_prod;
  logic [31:0] t_prod;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;

  assign q_prod = 32'(in_word.val) * 32'(in_word.q_fac);
  assign t_prod = 32'(in_word.val) * 32'(in_word.t_fac);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
    if (!hold && in_valid) begin
      out_word.sector <= in_word.sector;
      out_word.val    <= in_word.val;
      out_word.p      <= in_word.p;
      out_word.q_num  <= q_prod[31:16];
      out_word.t_num  <= t_prod[31:16];
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsv_rgb_pack.sv
// Stage 4: finish q/t, order channels by sector, pack RGB565 into the output register.
// Depends on hsv_rgb_pkg.
`default_nettype none

module hsv_rgb_pack (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire hsv_rgb_pkg::s3_word_t in_word,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [15:0]                color
);

  logic       hold;
  logic [7:0] q;
  logic [7:0] t;
  logic [7:0] r;
  logic [7:0] g;
  logic [7:0] b;

  assign hold     = out_valid && out_stall;
  assign in_stall = hold;

  assign q = hsv_rgb_pkg::div255(in_word.q_num);
  assign t = hsv_rgb_pkg::div255(in_word.t_num);

  always_comb begin
    case (in_word.sector)
      hsv_rgb_pkg::SEC_RED_YEL: begin
        r = in_word.val; g = t;           b = in_word.p;
      end
      hsv_rgb_pkg::SEC_YEL_GRN: begin
        r = q;           g = in_word.val; b = in_word.p;
      end
      hsv_rgb_pkg::SEC_GRN_CYN: begin
        r = in_word.p;   g = in_word.val; b = t;
      end
      hsv_rgb_pkg::SEC_CYN_BLU: begin
        r = in_word.p;   g = q;           b = in_word.val;
      end
      hsv_rgb_pkg::SEC_BLU_MAG: begin
        r = t;           g = in_word.p;   b = in_word.val;
      end
      default: begin
        r = in_word.val; g = in_word.p;   b = q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (!hold) begin
      out_valid <= in_valid;
    end
    if (!hold && in_valid) begin
      color <= {r[7:3], g[7:2], b[7:3]};
    end
  end

endmodule

`default_nettype wire

### rtl/core/hsv_rgb_checker.sv
// Port-level checks for the HSV to RGB565 converter, bound to the top level.
// Depends on hsv_to_rgb565 for the bind target only.
`default_nettype none

module hsv_rgb_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [15:0] color
);

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(color))
    else $error("stalled output word dropped or changed");

  // Drop everything at reset.
  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

  // Never push back while the output side is free.
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !out_stall |-> !in_stall)
    else $error("input stalled while output is free");

  // Deliver an accepted word while the output side stays free behind it.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) ##1 !out_stall ##1 !out_stall ##1 !out_stall
      |=> out_valid)
    else $error("accepted word did not reach the output in time");

endmodule

bind hsv_to_rgb565 hsv_rgb_checker u_hsv_rgb_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .color     (color)
);

`default_nettype wire

### tb/sv/hsv_to_rgb565_tb.sv
// Self-checking testbench for the hsv_to_rgb565 pixel converter.
// Depends on hsv_rgb_pkg (sector enum, full-scale constants) and the RTL top.
module hsv_to_rgb565_tb;

  localparam int RandomPixels = 1300;
  localparam int IdleLimit    = 2000;  // cycles with no word moving on either side
  localparam int QuietTail    = 150;   // pending words left when idling stops
  localparam int LongHold     = 80;    // one long output hold-off, in cycles
  localparam int HoldAfter    = 400;   // accepted input words before that hold
  localparam int DrainCycles  = 8;     // pipeline is 4 deep; settle a bit longer

  // One pending input word; wait_empty holds it back until every
  // color in flight has come out.
  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic        wait_empty;
  } pixel_t;

  // One predicted color, with the inputs that produced it for diagnostics.
  typedef struct packed {
    logic [15:0] hue;
    logic [7:0]  sat;
    logic [7:0]  val;
    logic [15:0] color;
  } color_due_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] hue = '0;
  logic [7:0]  saturation = '0;
  logic [7:0]  brightness = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] color;

  pixel_t     pixel_q[$];      // words still to be offered
  color_due_t colors_due[$];   // predicted colors, oldest first

  int unsigned n_in = 0;
  int unsigned n_out = 0;
  int unsigned n_directed = 0;
  int unsigned mismatches = 0;
  int unsigned sector_hits[6];
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  bit          done = 1'b0;

  hsv_to_rgb565 u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .color      (color)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Idling stops once only the tail of the stimulus is left.
  function automatic bit quiet();
    return pixel_q.size() < QuietTail;
  endfunction

  // Exact integer HSV to RGB565: split hue*6 into sector and fraction, form
  // p, q and t at full precision, truncate each to 8 bits, order by sector,
  // then keep the top 5/6/5 bits of red/green/blue.
  function automatic logic [15:0] rgb565_of(input logic [15:0] h, input logic [7:0] s,
                                            input logic [7:0] v);
    logic [18:0] h6;
    hsv_rgb_pkg::sector_t sec;
    logic [63:0] frac, s64, v64, den;
    logic [31:0] p_wide;
    logic [7:0]  p, q, t, r, g, b;
    h6     = {3'b000, h} * 19'd6;
    sec    = hsv_rgb_pkg::sector_t'(h6[18:16]);
    frac   = {48'd0, h6[15:0]};
    s64    = {56'd0, s};
    v64    = {56'd0, v};
    den    = {40'd0, hsv_rgb_pkg::DenFull};
    p_wide = ({24'd0, v} * ({24'd0, hsv_rgb_pkg::FullLevel} - {24'd0, s}))
             / {24'd0, hsv_rgb_pkg::FullLevel};
    p      = p_wide[7:0];
    q      = 8'((v64 * (den - frac * s64)) / den);
    t      = 8'((v64 * (den - (64'd65536 - frac) * s64)) / den);
    case (sec)
      hsv_rgb_pkg::SEC_RED_YEL: begin r = v; g = t; b = p; end
      hsv_rgb_pkg::SEC_YEL_GRN: begin r = q; g = v; b = p; end
      hsv_rgb_pkg::SEC_GRN_CYN: begin r = p; g = v; b = t; end
      hsv_rgb_pkg::SEC_CYN_BLU: begin r = p; g = q; b = v; end
      hsv_rgb_pkg::SEC_BLU_MAG: begin r = t; g = p; b = v; end
      default:                  begin r = v; g = p; b = q; end
    endcase
    return {r[7:3], g[7:2], b[7:3]};
  endfunction

  // Print one line per mismatch and count every one.
  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] MISMATCH: %s", $realtime, what);
  endtask

  task automatic queue_pixel(input logic [15:0] h, input logic [7:0] s, input logic [7:0] v,
                             input logic wait_empty);
    pixel_t px;
    px.hue        = h;
    px.sat        = s;
    px.val        = v;
    px.wait_empty = wait_empty;
    pixel_q.push_back(px);
  endtask

  function automatic logic [7:0] corner_level();
    case ($urandom_range(0, 6))
      0: return 8'd0;
      1: return 8'd1;
      2: return 8'd127;
      3: return 8'd128;
      4: return 8'd254;
      5: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  // Driver: record each accepted word's prediction, hold a stalled word,
  // otherwise advance to the next pending word or idle for a burst.
  always @(posedge clk) begin
    pixel_t     nxt;
    color_due_t due;
    logic [18:0] h6;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        due.hue   = hue;
        due.sat   = saturation;
        due.val   = brightness;
        due.color = rgb565_of(hue, saturation, brightness);
        colors_due.push_back(due);
        h6 = {3'b000, hue} * 19'd6;
        sector_hits[h6[18:16]]++;
        n_in++;
      end
      if (in_valid && in_stall) begin
        // hold the stalled word as it is
      end else if (send_gap != 0) begin
        in_valid <= 1'b0;
        send_gap <= send_gap - 1;
      end else if (pixel_q.size() != 0 &&
                   !(pixel_q[0].wait_empty && colors_due.size() != 0)) begin
        nxt = pixel_q.pop_front();
        hue        <= nxt.hue;
        saturation <= nxt.sat;
        brightness <= nxt.val;
        in_valid   <= 1'b1;
        // Keep offering while the receiver is held off so the pipe fills.
        if (!quiet() && hold_left == 0 && $urandom_range(0, 15) == 0)
          send_gap <= $urandom_range(1, 12);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: check each accepted color against the oldest prediction, and
  // drive out_stall: random bursts until the tail, plus one long hold-off.
  always @(posedge clk) begin
    color_due_t due;
    if (rst) begin
      out_stall <= 1'b0;
      recv_gap  <= 0;
      hold_left <= 0;
      hold_done <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_out++;
        if (colors_due.size() == 0) begin
          report_mismatch($sformatf("color %04h with no word pending", color));
        end else begin
          due = colors_due.pop_front();
          if (color !== due.color)
            report_mismatch($sformatf("hue %04h sat %02h val %02h: color %04h, want %04h",
                                      due.hue, due.sat, due.val, color, due.color));
        end
      end
      if (!hold_done && n_in >= HoldAfter) begin
        hold_left <= LongHold;
        hold_done <= 1'b1;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= (hold_left > 1);
      end else if (recv_gap != 0) begin
        recv_gap  <= recv_gap - 1;
        out_stall <= 1'b1;
      end else if (!quiet() && $urandom_range(0, 11) == 0) begin
        recv_gap  <= $urandom_range(0, 11);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  initial begin
    int unsigned idle;
    idle = 0;
    while (!done && idle < IdleLimit) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall))
        idle = 0;
      else
        idle++;
    end
    if (!done) begin
      $display("timeout: %0d idle cycles, %0d colors outstanding", idle, colors_due.size());
      $display("hsv_to_rgb565_tb: done, errors");
      $finish;
    end
  end

  initial begin
    int unsigned k;
    logic [31:0] base;
    logic [15:0] h;

    // Directed: black, white, pure red, both sides of every sector boundary,
    // hue just below a full turn, grays, and alternating bit patterns.
    queue_pixel(16'd0,     8'd0,   8'd0,   1'b0);
    queue_pixel(16'd0,     8'd255, 8'd255, 1'b0);
    queue_pixel(16'd65535, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd10922, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd10923, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd21845, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd21846, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd32767, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd32768, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd43690, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd43691, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd54613, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd54614, 8'd255, 8'd255, 1'b0);
    queue_pixel(16'd65535, 8'd0,   8'd200, 1'b0);
    queue_pixel(16'd12345, 8'd0,   8'd255, 1'b0);
    queue_pixel(16'd30000, 8'd128, 8'd0,   1'b0);
    queue_pixel(16'hAAAA,  8'h55,  8'hAA,  1'b0);
    queue_pixel(16'h5555,  8'hAA,  8'h55,  1'b0);
    queue_pixel(16'd40000, 8'd1,   8'd254, 1'b0);
    queue_pixel(16'd50000, 8'd254, 8'd1,   1'b0);
    queue_pixel(16'd65535, 8'd255, 8'd1,   1'b0);
    queue_pixel(16'd5461,  8'd128, 8'd128, 1'b0);
    n_directed = pixel_q.size();

    // Random: mostly uniform, some near sector boundaries, some corner levels.
    // Two words wait for the pipe to drain first: the one after the directed
    // part and one halfway through.
    for (int i = 0; i < RandomPixels; i++) begin
      k = $urandom_range(0, 9);
      if (k <= 5) begin
        h = 16'($urandom);
        queue_pixel(h, 8'($urandom), 8'($urandom), (i == 0) || (i == RandomPixels / 2));
      end else if (k <= 7) begin
        base = ($urandom_range(0, 6) * 32'd65536) / 32'd6;
        h    = 16'(base + $urandom_range(0, 6) - 3);
        queue_pixel(h, corner_level(), corner_level(), (i == 0) || (i == RandomPixels / 2));
      end else begin
        h = 16'($urandom);
        queue_pixel(h, corner_level(), corner_level(), (i == 0) || (i == RandomPixels / 2));
      end
    end

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Wait for every word to be taken and every color to come back.
    while (pixel_q.size() != 0 || in_valid || colors_due.size() != 0)
      @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    done = 1'b1;

    if (colors_due.size() != 0)
      report_mismatch($sformatf("%0d colors never came out", colors_due.size()));

    $display("converted %0d pixels (%0d directed), %0d colors checked, %0d mismatches",
             n_in, n_directed, n_out, mismatches);
    $display("per hue sector: %0d %0d %0d %0d %0d %0d, with a long output hold and two drains",
             sector_hits[0], sector_hits[1], sector_hits[2],
             sector_hits[3], sector_hits[4], sector_hits[5]);
    if (mismatches == 0)
      $display("hsv_to_rgb565_tb: done, clean");
    else
      $display("hsv_to_rgb565_tb: done, errors");
    $finish;
  end

endmodule
